### rtl/core/smsd_pkg.sv
package smsd_pkg;

  // Sizes of the trailing window and of the sample value range
  localparam int unsigned WINDOW_MAX   = 1024;
  localparam int unsigned VALUE_LEVELS = 256;

  localparam int unsigned SAMPLE_W = $clog2(VALUE_LEVELS);
  localparam int unsigned SLOT_W   = $clog2(WINDOW_MAX);
  localparam int unsigned WLEN_W   = SLOT_W + 1;
  localparam int unsigned COUNT_W  = WLEN_W;
  localparam int unsigned MED_W    = SAMPLE_W + 1;
  localparam int unsigned FLAGS_W  = 32;

  // Result word layout
  localparam int unsigned OUT_FIELDS_W = 1 + 1 + MED_W + FLAGS_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

### rtl/core/smsd_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data
module smsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/sliding_median_spike_detector_unit.sv
// Sliding-median spike detector. Each input word carries one 8-bit sample; one
// result word comes back per sample. Once window_length earlier samples of the
// current sequence exist, the sample is flagged when it is at least twice their
// median (the sum of the two middle values for an even window), and flags are
// counted with saturation. in_tlast ends a sequence and clears the window and
// the flag count after its result; a configuration write clears the window but
// keeps the flag count. Configuration is written only while the block is idle.
// Samples are handled one at a time. While the window is still filling, the
// sample passes through ST_IRD, ST_IWR and ST_DONE, where the result word is
// registered, and the next sample can be taken in the cycle after. With a full
// window the median search walks the value histogram one bin per cycle, reading
// the histogram memory, and stops at the bin holding the upper middle rank;
// ST_DRD, ST_DWR, ST_IRD and ST_IWR then swap the oldest sample for the new one
// in the histogram before ST_DONE. A result word stalled by out_tready holds
// the sequencer, and with it the input, until it leaves. The histogram and the
// sample history sit in two single-read-port memories; histogram bins carry
// valid bits, so no clearing pass is needed after reset or at the end of a
// sequence.
module sliding_median_spike_detector_unit
  import smsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration: window_length
  input  logic                  cfg_wr_en,
  input  logic [WLEN_W-1:0]     cfg_wr_data,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] sample
  input  logic                  in_tlast,    // last_item
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata    // flagged, window_full,
                                             // median_doubled[8:0],
                                             // flag_count[31:0], zero pad
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRD,
    ST_DWR,
    ST_IRD,
    ST_IWR,
    ST_DONE
  } state_t;

  state_t state_r;

  // Sequence state
  logic [WLEN_W-1:0]       window_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [WLEN_W-1:0]       seen_r;
  logic [FLAGS_W-1:0]      flags_r;
  logic [VALUE_LEVELS-1:0] bin_valid_r;

  // Per-sample working registers
  logic [SAMPLE_W-1:0] sample_r;
  logic                last_r;
  logic                full_r;
  logic [SLOT_W-1:0]   cur_slot_r;
  logic [SLOT_W-1:0]   k_lo_r;
  logic [SLOT_W-1:0]   k_hi_r;
  logic [SAMPLE_W-1:0] bin_r;
  logic [COUNT_W:0]    acc_r;
  logic                lo_found_r;
  logic [SAMPLE_W-1:0] lo_r;
  logic [SAMPLE_W-1:0] hi_r;
  logic                hval_r;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Memory ports
  logic                hist_we;
  logic [SAMPLE_W-1:0] hist_waddr;
  logic [COUNT_W-1:0]  hist_wdata;
  logic                hist_re;
  logic [SAMPLE_W-1:0] hist_raddr;
  logic [COUNT_W-1:0]  hist_rdata;
  logic                line_we;
  logic                line_re;
  logic [SLOT_W-1:0]   line_raddr;
  logic [SAMPLE_W-1:0] line_rdata;

  // Combinational helpers
  logic [WLEN_W-1:0]   w_eff;
  logic [SLOT_W-1:0]   half;
  logic [SLOT_W-1:0]   slot_wrap;
  logic                in_acc;
  logic [COUNT_W-1:0]  cnt;
  logic [COUNT_W:0]    acc_nxt;
  logic [MED_W-1:0]    doubled;
  logic                flag;
  logic [FLAGS_W-1:0]  flags_nxt;
  logic [WLEN_W-1:0]   slot_inc;
  logic                out_free;

  // Window length clamped to 1..WINDOW_MAX
  always_comb begin
    if (window_r == '0) begin
      w_eff = WLEN_W'(1);
    end else if (window_r > WLEN_W'(WINDOW_MAX)) begin
      w_eff = WLEN_W'(WINDOW_MAX);
    end else begin
      w_eff = window_r;
    end
  end

  assign half      = w_eff[WLEN_W-1:1];
  assign slot_wrap = ({1'b0, slot_r} >= w_eff) ? '0 : slot_r;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Histogram count of the bin just read; invalid bins read as zero
  assign cnt     = hval_r ? hist_rdata : '0;
  assign acc_nxt = acc_r + {1'b0, cnt};

  // Result of the current sample
  assign doubled   = full_r ? ({1'b0, lo_r} + {1'b0, hi_r}) : '0;
  assign flag      = full_r && ({1'b0, sample_r} >= doubled);
  assign flags_nxt = (flag && (flags_r != '1)) ? flags_r + FLAGS_W'(1) : flags_r;
  assign slot_inc  = {1'b0, cur_slot_r} + WLEN_W'(1);

  // Memory control
  always_comb begin
    hist_re    = 1'b0;
    hist_raddr = bin_r + SAMPLE_W'(1);
    hist_we    = 1'b0;
    hist_waddr = sample_r;
    hist_wdata = cnt + COUNT_W'(1);
    line_re    = in_acc;
    line_raddr = slot_wrap;
    line_we    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        hist_re    = in_acc;
        hist_raddr = '0;
      end
      ST_WALK: begin
        hist_re = (bin_r != '1);
      end
      ST_DRD: begin
        hist_re    = 1'b1;
        hist_raddr = line_rdata;
      end
      ST_DWR: begin
        hist_we    = (cnt != '0);
        hist_waddr = line_rdata;
        hist_wdata = cnt - COUNT_W'(1);
      end
      ST_IRD: begin
        hist_re    = 1'b1;
        hist_raddr = sample_r;
      end
      ST_IWR: begin
        hist_we = 1'b1;
        line_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  smsd_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (VALUE_LEVELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  smsd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (cur_slot_r),
    .wdata (sample_r),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // Sequencer, sequence state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WLEN_W'(1);
      slot_r      <= '0;
      seen_r      <= '0;
      flags_r     <= '0;
      bin_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (hist_re) begin
        hval_r <= bin_valid_r[hist_raddr];
      end
      case (state_r)
        ST_IDLE: begin
          if (cfg_wr_en) begin
            window_r    <= cfg_wr_data;
            slot_r      <= '0;
            seen_r      <= '0;
            bin_valid_r <= '0;
          end
          if (in_acc) begin
            sample_r   <= in_tdata;
            last_r     <= in_tlast;
            full_r     <= (seen_r >= w_eff);
            cur_slot_r <= slot_wrap;
            k_lo_r     <= w_eff[0] ? half : half - SLOT_W'(1);
            k_hi_r     <= half;
            bin_r      <= '0;
            acc_r      <= '0;
            lo_found_r <= 1'b0;
            state_r    <= (seen_r >= w_eff) ? ST_WALK : ST_IRD;
          end
        end
        // One histogram bin per cycle until the upper middle rank is reached
        ST_WALK: begin
          acc_r <= acc_nxt;
          bin_r <= bin_r + SAMPLE_W'(1);
          if (!lo_found_r && (acc_nxt > {2'b00, k_lo_r})) begin
            lo_r       <= bin_r;
            lo_found_r <= 1'b1;
          end
          if (acc_nxt > {2'b00, k_hi_r}) begin
            hi_r    <= bin_r;
            state_r <= ST_DRD;
          end else if (bin_r == '1) begin
            hi_r    <= '1;
            if (!lo_found_r) begin
              lo_r <= '1;
            end
            state_r <= ST_DRD;
          end
        end
        ST_DRD: begin
          state_r <= ST_DWR;
        end
        ST_DWR: begin
          state_r <= ST_IRD;
        end
        ST_IRD: begin
          state_r <= ST_IWR;
        end
        ST_IWR: begin
          bin_valid_r[sample_r] <= 1'b1;
          state_r               <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_r <= OUT_DATA_W'({flags_nxt, doubled, full_r, flag});
            if (last_r) begin
              slot_r      <= '0;
              seen_r      <= '0;
              flags_r     <= '0;
              bin_valid_r <= '0;
            end else begin
              slot_r <= (slot_inc >= w_eff) ? '0 : slot_inc[SLOT_W-1:0];
              if (seen_r < w_eff) begin
                seen_r <= seen_r + WLEN_W'(1);
              end
              flags_r <= flags_nxt;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The running sum of bin counts never shrinks during the walk
  a_walk_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && $past(state_r == ST_WALK) |-> acc_r >= $past(acc_r))
    else $error("histogram walk sum decreased");

  // The fill count never exceeds the effective window
  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= w_eff)
    else $error("samples seen beyond window");

  // A flag needs a full window
  a_flag_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> out_data_r[1])
    else $error("flag without full window");

  // Without a full window the doubled median reads zero
  a_median_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[1] |-> out_data_r[MED_W+1:2] == '0)
    else $error("median reported before window full");

  // A new result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && !out_tready |=> state_r == ST_DONE)
    else $error("result overwritten while stalled");

endmodule

### test/tb_sliding_median_spike_detector_unit.sv
`timescale 1ns / 100ps

module tb_sliding_median_spike_detector_unit;
  import smsd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_TAIL   = 300;   // above the worst-case time for one sample
  localparam int unsigned LONG_HOLD    = 900;

  // One expected result word
  typedef struct {
    bit        flagged;
    bit        full;
    bit [8:0]  med2;
    bit [31:0] count;
  } spike_word_t;

  // Running copy of the detector: window history, histogram, flag count
  class spike_predictor;
    int unsigned bin_count [VALUE_LEVELS];
    bit [7:0]    ring [WINDOW_MAX];
    int unsigned slot, seen, window;
    bit [31:0]   flags;
    spike_word_t due_words[$];
    int unsigned errors;

    function new();
      clear_window();
      flags  = 0;
      window = 1;
      errors = 0;
    endfunction

    function void clear_window();
      foreach (bin_count[i]) bin_count[i] = 0;
      slot = 0;
      seen = 0;
    endfunction

    function void set_window(bit [WLEN_W-1:0] len);
      window = len;
      clear_window();
    endfunction

    // value holding 0-based rank k in sorted order
    function int unsigned value_at_rank(int unsigned k);
      int unsigned acc;
      acc = 0;
      for (int v = 0; v < VALUE_LEVELS; v++) begin
        acc += bin_count[v];
        if (acc > k) return v;
      end
      return VALUE_LEVELS - 1;
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    // accepted input word -> expected result
    function void note_word(bit [7:0] s, bit last);
      int unsigned w, half, old;
      spike_word_t r;
      w = (window == 0) ? 1 : (window > WINDOW_MAX) ? WINDOW_MAX : window;
      if (slot >= w) slot = 0;
      r.full    = (seen >= w);
      r.flagged = 0;
      r.med2    = 0;
      if (r.full) begin
        half = w >> 1;
        if (w[0]) r.med2 = 9'(2 * value_at_rank(half));
        else      r.med2 = 9'(value_at_rank(half - 1) + value_at_rank(half));
        r.flagged = (s >= r.med2);
        if (r.flagged && flags != 32'hFFFF_FFFF) flags++;
      end
      r.count = flags;
      due_words.push_back(r);

      // slide the window
      if (r.full) begin
        old = ring[slot];
        if (bin_count[old] > 0) bin_count[old]--;
      end
      ring[slot] = s;
      bin_count[s]++;
      slot++;
      if (slot >= w) slot = 0;
      if (seen < w) seen++;
      if (last) begin
        clear_window();
        flags = 0;
      end
    endfunction

    // accepted result word vs oldest expectation
    task check_word(logic [OUT_DATA_W-1:0] d);
      spike_word_t e;
      if (due_words.size() == 0) begin
        report($sformatf("result word 0x%h with nothing outstanding", d));
        return;
      end
      e = due_words.pop_front();
      if (d[0] !== e.flagged)
        report($sformatf("flagged %b, want %b", d[0], e.flagged));
      if (d[1] !== e.full)
        report($sformatf("window_full %b, want %b", d[1], e.full));
      if (d[10:2] !== e.med2)
        report($sformatf("median_doubled %0d, want %0d", d[10:2], e.med2));
      if (d[42:11] !== e.count)
        report($sformatf("flag_count %0d, want %0d", d[42:11], e.count));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [WLEN_W-1:0]     cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;    // [7:0] sample
  logic                  in_tlast;    // last_item
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // flagged, window_full, median_doubled[8:0],
                                      // flag_count[31:0], zero pad

  spike_predictor sb = new();

  int unsigned cycles;
  int unsigned burst_left;
  int unsigned hold_asked;

  sliding_median_spike_detector_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("ERROR: timeout with %0d result words outstanding", sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result sampling
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  // receiver: changing stall modes, plus long hold-offs on request
  initial begin
    int unsigned hold_left, hold_done, mode, mode_left, tick;
    hold_left = 0;
    hold_done = 0;
    mode_left = 0;
    mode      = 0;
    tick      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          1: begin
            out_tready = 1'($urandom_range(0, 1));
          end
          2: begin
            out_tready = ((tick & 3) == 0);
          end
          default: begin
            out_tready = 1'b1;
          end
        endcase
      end
    end
  end

  // push one word, bursts with random gaps between them
  task automatic send_word(input bit [7:0] s, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = s;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    sb.note_word(s, last);
  endtask

  // sender idles until every expected word is back, then a tail
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_window(input bit [WLEN_W-1:0] len);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = len;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_window(len);
  endtask

  // mostly a quiet baseline around a level, some spikes, some noise
  function automatic bit [7:0] pick_sample(input int unsigned level);
    int unsigned r, v;
    r = $urandom_range(0, 99);
    if (r < 75)      v = level + $urandom_range(0, 20);
    else if (r < 88) v = $urandom_range(2 * level, 2 * level + 60);
    else             v = $urandom_range(0, 255);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // one window setting, sequences mostly long enough to fill the window
  task automatic run_phase(input bit [WLEN_W-1:0] len, input int unsigned n_words,
                           input bit mid_drain, input bit long_hold);
    int unsigned w, seq_left, level;
    w = (len == 0) ? 1 : (len > WINDOW_MAX) ? WINDOW_MAX : len;
    write_window(len);
    if (long_hold) hold_asked++;
    seq_left = 0;
    level    = 0;
    for (int unsigned i = 0; i < n_words; i++) begin
      if (seq_left == 0) begin
        seq_left = ($urandom_range(0, 99) < 85) ? $urandom_range(w + 1, 3 * w + 10)
                                                : $urandom_range(1, w);
        level    = $urandom_range(0, 120);
      end
      if (mid_drain && i == n_words / 2) wait_drained();
      send_word(pick_sample(level), seq_left == 1);
      seq_left--;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cycles      = 0;
    burst_left  = 0;
    hold_asked  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // window of one from reset: zero median, extreme samples, sequence end
    send_word(8'd0,   1'b0);
    send_word(8'd0,   1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd254, 1'b0);
    send_word(8'd127, 1'b1);

    // even window: the doubled median is the sum of the two middle values
    write_window(11'd2);
    send_word(8'd10,  1'b0);
    send_word(8'd20,  1'b0);
    send_word(8'd15,  1'b0);
    send_word(8'd40,  1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd0,   1'b0);

    // zero length acts as one; flag count carries over the write
    write_window(11'd0);
    send_word(8'd7,  1'b0);
    send_word(8'd14, 1'b0);
    send_word(8'd13, 1'b1);

    // odd window, flag exactly at twice the median
    write_window(11'd3);
    send_word(8'd1,   1'b0);
    send_word(8'd2,   1'b0);
    send_word(8'd3,   1'b0);
    send_word(8'd4,   1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd0,   1'b1);

    // random sequences over a range of window lengths
    run_phase(11'd1,  45, 1'b0, 1'b0);
    run_phase(11'd2,  45, 1'b1, 1'b0);
    run_phase(11'd3,  45, 1'b0, 1'b0);
    run_phase(11'd4,  45, 1'b0, 1'b1);
    run_phase(11'd5,  45, 1'b0, 1'b0);
    run_phase(11'd8,  45, 1'b0, 1'b0);
    run_phase(11'd16, 60, 1'b1, 1'b0);
    run_phase(11'd31, 100, 1'b0, 1'b1);
    run_phase(11'd48, 200, 1'b0, 1'b0);
    run_phase(11'($urandom_range(1, 40)), 80, 1'b1, 1'b0);
    run_phase(11'd1024, 15, 1'b0, 1'b0);

    // out-of-range length clamps to the deepest window
    write_window(11'd2047);
    for (int i = 0; i < 40; i++) send_word(8'($urandom_range(0, 255)), i == 39);

    run_phase(11'd7, 60, 1'b0, 1'b0);

    wait_drained();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/smsd_pkg.sv
rtl/core/smsd_ram.sv
rtl/core/sliding_median_spike_detector_unit.sv
test/tb_sliding_median_spike_detector_unit.sv
